FILE: hdl/bda_pkg.sv
// Package for the packed BCD decimal ALU: field widths, command and status
// codes, and the single-digit helpers shared by the datapath modules.
// No dependencies.
package bda_pkg;

    localparam int DIGIT_W  = 4;
    localparam int FIELD_W  = 64;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEGATIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd3;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef logic [DIGIT_W-1:0] digit_t;

    // A nibble holding 10..15 reads as 9.
    function automatic digit_t sat_digit(input digit_t d);
        digit_t r;
        r = (d > DIGIT_MAX) ? DIGIT_MAX : d;
        return r;
    endfunction

    // One decimal digit of an add or subtract; bit 4 is carry or borrow out.
    function automatic logic [DIGIT_W:0] bcd_digit_op(input digit_t x, input digit_t y,
                                                      input logic cin, input logic sub);
        logic [DIGIT_W:0] s;
        logic [DIGIT_W:0] r;
        if (sub)
        begin
            s = {1'b0, x} - {1'b0, y} - {{DIGIT_W{1'b0}}, cin};
            if (s[DIGIT_W])
                r = {1'b1, s[DIGIT_W-1:0] + 4'd10};
            else
                r = {1'b0, s[DIGIT_W-1:0]};
        end
        else
        begin
            s = {1'b0, x} + {1'b0, y} + {{DIGIT_W{1'b0}}, cin};
            if (s > 5'd9)
                r = {1'b1, s[DIGIT_W-1:0] + 4'd6};
            else
                r = {1'b0, s[DIGIT_W-1:0]};
        end
        return r;
    endfunction

endpackage

FILE: hdl/bda_if.sv
// Valid/ready channel interfaces for the BCD ALU request and response items.
// Depends on bda_pkg.
interface bda_req_if;
    logic                            valid;
    logic                            ready;
    logic [bda_pkg::CMD_W-1:0]       cmd;
    logic [bda_pkg::FIELD_W-1:0]     a_value;
    logic [bda_pkg::FIELD_W-1:0]     b_value;

    modport source (output valid, output cmd, output a_value, output b_value, input ready);
    modport sink   (input valid, input cmd, input a_value, input b_value, output ready);
endinterface

interface bda_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bda_pkg::FIELD_W-1:0]     result_value;
    logic                            a_greater;
    logic                            a_equal;
    logic [bda_pkg::STATUS_W-1:0]    status;

    modport source (output valid, output result_value, output a_greater, output a_equal,
                    output status, input ready);
    modport sink   (input valid, input result_value, input a_greater, input a_equal,
                    input status, output ready);
endinterface

FILE: hdl/bda_digit_slice.sv
// Digit-serial BCD adder/subtractor: one decimal digit per cycle while en is
// high, with a registered carry and a running nonzero flag. Depends on bda_pkg.
module bda_digit_slice (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 first,
    input  logic                 sub,
    input  bda_pkg::digit_t      x,
    input  bda_pkg::digit_t      y,
    output bda_pkg::digit_t      z,
    output logic                 cout,
    output logic                 nz
);

    logic                        carry_reg;
    logic                        nz_reg;
    logic                        cin;
    logic [bda_pkg::DIGIT_W:0]   op;

    assign cin  = first ? 1'b0 : carry_reg;
    assign op   = bda_pkg::bcd_digit_op(x, y, cin, sub);
    assign z    = op[bda_pkg::DIGIT_W-1:0];
    assign cout = op[bda_pkg::DIGIT_W];
    assign nz   = (z != '0) | (~first & nz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
            nz_reg    <= 1'b0;
        end
        else if (en)
        begin
            carry_reg <= cout;
            nz_reg    <= nz;
        end
    end

endmodule

FILE: hdl/bcd_decimal_alu_unit.sv
// Top level of the packed BCD decimal ALU: sequencer, operand registers and
// one shared digit slice. Depends on bda_pkg, bda_if and bda_digit_slice.
//
// One item is worked on at a time, and every operation runs through a single
// one-digit BCD adder/subtractor, one pass over all DIGITS+1 digit positions
// per full-width add or subtract. Each item first takes a compare pass that
// sets a_greater and a_equal. Add then takes one more pass, subtract none, and
// divide by zero none. Multiply takes, per digit of b, a shift step plus one
// add pass per unit of that digit, then a closing step. An overflow found at
// a shift ends it after that digit's passes; one found in an add pass ends it
// after that pass. Divide takes, per digit of a, a shift step plus one
// trial-subtract pass per quotient unit plus the failing trial, then a closing
// step. S_FIN then loads the result into the output register, first waiting
// for rsp.ready if the output is still full. The next request is taken in the
// idle cycle after that load.
module bcd_decimal_alu_unit #(
    parameter int DIGITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    bda_req_if.sink       req,
    bda_rsp_if.source     rsp
);

    localparam int NW  = bda_pkg::DIGIT_W * (DIGITS + 1);
    localparam int DW  = bda_pkg::DIGIT_W * DIGITS;
    localparam int CW  = $clog2(DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CMP, S_ADD, S_MSTEP, S_MADD, S_DSTEP, S_DTRIAL, S_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [NW-1:0]                   a_reg, a_next;
    logic [NW-1:0]                   b_reg, b_next;
    logic [NW-1:0]                   acc_reg, acc_next;
    logic [NW-1:0]                   z_reg, z_next;
    logic [NW-1:0]                   src_reg, src_next;
    logic [NW-1:0]                   q_reg, q_next;
    logic [NW-1:0]                   res_reg, res_next;
    logic [bda_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic [bda_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                            gt_reg, gt_next;
    logic                            eq_reg, eq_next;
    logic [CW-1:0]                   pcnt_reg, pcnt_next;
    logic [CW-1:0]                   outer_reg, outer_next;
    bda_pkg::digit_t                 rep_reg, rep_next;
    logic                            ovalid_reg, ovalid_next;
    logic [bda_pkg::FIELD_W-1:0]     ores_reg, ores_next;
    logic                            ogt_reg, ogt_next;
    logic                            oeq_reg, oeq_next;
    logic [bda_pkg::STATUS_W-1:0]    ost_reg, ost_next;

    logic [NW-1:0]                   a_dec, b_dec;
    logic                            in_pass, first, last, sub;
    bda_pkg::digit_t                 x, y, dz;
    logic                            cout, nz;
    logic [NW-1:0]                   z_shift;

    always_comb
    begin
        a_dec = '0;
        b_dec = '0;
        for (int k = 0; k < DIGITS; k++)
        begin
            a_dec[k*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
                bda_pkg::sat_digit(req.a_value[k*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W]);
            b_dec[k*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
                bda_pkg::sat_digit(req.b_value[k*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W]);
        end
    end

    assign in_pass = (state_reg == S_CMP) || (state_reg == S_ADD) ||
                     (state_reg == S_MADD) || (state_reg == S_DTRIAL);
    assign first   = (pcnt_reg == '0);
    assign last    = (pcnt_reg == CW'(DIGITS));
    assign sub     = (state_reg == S_CMP) || (state_reg == S_DTRIAL);
    assign x       = ((state_reg == S_MADD) || (state_reg == S_DTRIAL)) ?
                     acc_reg[bda_pkg::DIGIT_W-1:0] : a_reg[bda_pkg::DIGIT_W-1:0];
    assign y       = (state_reg == S_MADD) ? a_reg[bda_pkg::DIGIT_W-1:0]
                                           : b_reg[bda_pkg::DIGIT_W-1:0];
    assign z_shift = {dz, z_reg[NW-1:bda_pkg::DIGIT_W]};

    bda_digit_slice u_slice (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (in_pass),
        .first (first),
        .sub   (sub),
        .x     (x),
        .y     (y),
        .z     (dz),
        .cout  (cout),
        .nz    (nz)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = ovalid_reg;
    assign rsp.result_value = ores_reg;
    assign rsp.a_greater    = ogt_reg;
    assign rsp.a_equal      = oeq_reg;
    assign rsp.status       = ost_reg;

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        z_next      = z_reg;
        src_next    = src_reg;
        q_next      = q_reg;
        res_next    = res_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        gt_next     = gt_reg;
        eq_next     = eq_reg;
        pcnt_next   = pcnt_reg;
        outer_next  = outer_reg;
        rep_next    = rep_reg;
        ovalid_next = ovalid_reg;
        ores_next   = ores_reg;
        ogt_next    = ogt_reg;
        oeq_next    = oeq_reg;
        ost_next    = ost_reg;

        if (rsp.valid && rsp.ready)
            ovalid_next = 1'b0;

        // Each step of a pass rotates a, b and acc by one digit, so they
        // come back intact at the end of the pass.
        if (in_pass)
        begin
            a_next    = {a_reg[bda_pkg::DIGIT_W-1:0], a_reg[NW-1:bda_pkg::DIGIT_W]};
            b_next    = {b_reg[bda_pkg::DIGIT_W-1:0], b_reg[NW-1:bda_pkg::DIGIT_W]};
            acc_next  = {acc_reg[bda_pkg::DIGIT_W-1:0], acc_reg[NW-1:bda_pkg::DIGIT_W]};
            z_next    = z_shift;
            pcnt_next = last ? '0 : pcnt_reg + CW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    a_next      = a_dec;
                    b_next      = b_dec;
                    cmd_next    = req.cmd;
                    acc_next    = '0;
                    q_next      = '0;
                    res_next    = '0;
                    status_next = bda_pkg::ST_OK;
                    pcnt_next   = '0;
                    outer_next  = '0;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                if (last)
                begin
                    gt_next = ~cout & nz;
                    eq_next = ~nz;
                    case (cmd_reg)
                        bda_pkg::CMD_ADD: state_next = S_ADD;
                        bda_pkg::CMD_SUB:
                        begin
                            if (cout)
                                status_next = bda_pkg::ST_NEGATIVE;
                            else
                                res_next = z_shift;
                            state_next = S_FIN;
                        end
                        bda_pkg::CMD_MUL:
                        begin
                            // The last rotation of the pass puts b back in place.
                            src_next   = b_next;
                            state_next = S_MSTEP;
                        end
                        bda_pkg::CMD_DIV:
                        begin
                            if (b_reg == '0)
                            begin
                                status_next = bda_pkg::ST_DIV_ZERO;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                src_next   = a_next;
                                state_next = S_DSTEP;
                            end
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_ADD:
            begin
                if (last)
                begin
                    if (dz != '0)
                        status_next = bda_pkg::ST_OVERFLOW;
                    else
                        res_next = z_shift;
                    state_next = S_FIN;
                end
            end
            S_MSTEP:
            begin
                if ((status_reg != bda_pkg::ST_OK) || (outer_reg == CW'(DIGITS)))
                begin
                    if (status_reg == bda_pkg::ST_OK)
                        res_next = acc_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    // Times ten; a nonzero top digit means the product is too big.
                    if (acc_reg[DW-1 -: bda_pkg::DIGIT_W] != '0)
                        status_next = bda_pkg::ST_OVERFLOW;
                    acc_next   = {acc_reg[NW-bda_pkg::DIGIT_W-1:0], {bda_pkg::DIGIT_W{1'b0}}};
                    rep_next   = src_reg[DW-1 -: bda_pkg::DIGIT_W];
                    src_next   = {src_reg[NW-bda_pkg::DIGIT_W-1:0], {bda_pkg::DIGIT_W{1'b0}}};
                    outer_next = outer_reg + CW'(1);
                    if (src_reg[DW-1 -: bda_pkg::DIGIT_W] != '0)
                        state_next = S_MADD;
                end
            end
            S_MADD:
            begin
                if (last)
                begin
                    acc_next = z_shift;
                    rep_next = rep_reg - bda_pkg::digit_t'(1);
                    if (dz != '0)
                    begin
                        status_next = bda_pkg::ST_OVERFLOW;
                        state_next  = S_MSTEP;
                    end
                    else if (rep_reg == bda_pkg::digit_t'(1))
                        state_next = S_MSTEP;
                end
            end
            S_DSTEP:
            begin
                if (outer_reg == CW'(DIGITS))
                begin
                    res_next   = q_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    acc_next   = {acc_reg[NW-bda_pkg::DIGIT_W-1:0],
                                  src_reg[DW-1 -: bda_pkg::DIGIT_W]};
                    src_next   = {src_reg[NW-bda_pkg::DIGIT_W-1:0], {bda_pkg::DIGIT_W{1'b0}}};
                    rep_next   = '0;
                    outer_next = outer_reg + CW'(1);
                    state_next = S_DTRIAL;
                end
            end
            S_DTRIAL:
            begin
                if (last)
                begin
                    if (!cout)
                    begin
                        // Trial subtract fits: keep the remainder and count.
                        acc_next = z_shift;
                        rep_next = rep_reg + bda_pkg::digit_t'(1);
                    end
                    else
                    begin
                        q_next     = {q_reg[NW-bda_pkg::DIGIT_W-1:0], rep_reg};
                        state_next = S_DSTEP;
                    end
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = bda_pkg::FIELD_W'(res_reg[DW-1:0]);
                    ogt_next    = gt_reg;
                    oeq_next    = eq_reg;
                    ost_next    = status_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            pcnt_reg   <= '0;
            outer_reg  <= '0;
            rep_reg    <= '0;
            status_reg <= bda_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            pcnt_reg   <= pcnt_next;
            outer_reg  <= outer_next;
            rep_reg    <= rep_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        z_reg    <= z_next;
        src_reg  <= src_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
        cmd_reg  <= cmd_next;
        gt_reg   <= gt_next;
        eq_reg   <= eq_next;
        ores_reg <= ores_next;
        ogt_reg  <= ogt_next;
        oeq_reg  <= oeq_next;
        ost_reg  <= ost_next;
    end

endmodule

FILE: hdl/bda_checker.sv
// Port-level checker for the BCD ALU, bound to the top level.
// Depends on bda_pkg and bcd_decimal_alu_unit.
module bda_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic [bda_pkg::FIELD_W-1:0]     result_value,
    input  logic                            a_greater,
    input  logic                            a_equal,
    input  logic [bda_pkg::STATUS_W-1:0]    status
);

    // Any error status returns a zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != bda_pkg::ST_OK) |-> result_value == '0)
        else $error("nonzero result with error status");

    // The comparison flags never both claim a relation.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(a_greater && a_equal))
        else $error("a_greater and a_equal both set");

    // A negative difference means b exceeds a.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bda_pkg::ST_NEGATIVE) |-> !a_greater && !a_equal)
        else $error("negative status with a not below b");

    // A stalled result item holds its valid, result and status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) && $stable(status))
        else $error("stalled result item changed");

endmodule

bind bcd_decimal_alu_unit bda_checker u_bda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .a_greater    (rsp.a_greater),
    .a_equal      (rsp.a_equal),
    .status       (rsp.status)
);
